### sv/pie_pkg.sv
// Shared types and codes for the position insert/erase list.
package pie_pkg;

    localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_POP_BACK   = 3'd2;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [2:0] MODE_INSERT     = 3'd4;
    localparam logic [2:0] MODE_ERASE      = 3'd5;
    localparam logic [2:0] MODE_READ       = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  position;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [4:0]  count;
        logic        is_empty;
    } out_item_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic open_gap;
        logic close_gap;
        logic rd_en;
    } cell_cmd_t;

endpackage

### sv/pie_cell.sv
// One storage cell of the list row: holds one element and shifts with its neighbors.
module pie_cell #(
    parameter int IDX        = 0,
    parameter int IW         = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    aclk,
    input  pie_pkg::cell_cmd_t      cmd,
    input  logic [IW-1:0]           at,
    input  logic [DATA_WIDTH-1:0]   wr_data,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    output logic [DATA_WIDTH-1:0]   data,
    output logic [DATA_WIDTH-1:0]   hit_data
);
    import pie_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.open_gap) begin
            if (MY_IDX > at) begin
                data_next = left_data;
            end else if (MY_IDX == at) begin
                data_next = wr_data;
            end
        end else if (cmd.close_gap) begin
            // Cells at or above the gap pull from the right; cells past the
            // count end up with stale data that is never read.
            if (MY_IDX >= at) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign hit_data = (MY_IDX == at) ? data_reg : '0;

endmodule

### sv/pie_ctrl.sv
// Operation decode: status, new count and the command for the cell row.
module pie_ctrl #(
    parameter int CAPACITY = 16,
    parameter int IW       = 4,
    parameter int CW       = 5
) (
    input  pie_pkg::in_item_t  item,
    input  logic [CW-1:0]      count,
    output pie_pkg::cell_cmd_t cmd,
    output logic [IW-1:0]      at,
    output logic [1:0]         status,
    output logic [CW-1:0]      count_next
);
    import pie_pkg::*;

    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam logic [CMPW-1:0] CAP_W = CMPW'(CAPACITY);

    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] at_w;
    logic            full;
    logic            empty;

    assign pos_w = CMPW'(item.position);
    assign cnt_w = CMPW'(count);
    assign full  = (cnt_w >= CAP_W);
    assign empty = (cnt_w == '0);

    always_comb begin
        cmd    = '0;
        status = ST_OK;
        at_w   = '0;
        case (item.mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.open_gap = 1'b1;
                    at_w = (item.mode == MODE_PUSH_BACK) ? cnt_w : '0;
                end
            end
            MODE_POP_BACK, MODE_POP_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.close_gap = 1'b1;
                    at_w = (item.mode == MODE_POP_BACK) ? (cnt_w - CMPW'(1)) : '0;
                end
            end
            MODE_INSERT: begin
                if (pos_w > cnt_w) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.open_gap = 1'b1;
                    at_w = pos_w;
                end
            end
            MODE_ERASE, MODE_READ: begin
                at_w = pos_w;
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    status = ST_BADPOS;
                end else if (item.mode == MODE_ERASE) begin
                    cmd.close_gap = 1'b1;
                end else begin
                    cmd.rd_en = 1'b1;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign at = at_w[IW-1:0];

    always_comb begin
        count_next = count;
        if (cmd.open_gap) begin
            count_next = count + CW'(1);
        end else if (cmd.close_gap) begin
            count_next = count - CW'(1);
        end
    end

endmodule

### sv/position_insert_erase_list.sv
// Top level of the fixed-capacity position insert/erase list.
// Usage: each input item on s_item carries a mode, a position and a value; the
// block answers each item with exactly one result item on m_item giving the
// status, the value read, the new element count and an empty flag.
// Both channels use valid/ready; an item moves when valid and ready are high.
// The elements live in a row of CAPACITY cells. The operation is decoded and
// broadcast to every cell, and each cell compares its own index with the
// position and shifts toward or away from its neighbor in the same cycle.
// The result is registered and appears on m_item in the cycle after the item is accepted.
// The block takes one item per cycle while m_ready stays high, since each cell
// updates as its item is accepted and the output register is one deep.
// When the receiver stalls, the output register holds its result and s_ready
// drops until the result is taken; it rises again in the cycle m_ready is high.
// Reset (aresetn low, synchronous) empties the list and drops m_valid; the
// cell contents are not cleared, since entries at or above the count are
// never read.
module position_insert_erase_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pie_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pie_pkg::out_item_t  m_item
);
    import pie_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_valid_reg;
    out_item_t             out_reg;
    out_item_t             out_next;

    cell_cmd_t             cmd;
    cell_cmd_t             cell_cmd;
    logic [IW-1:0]         at;
    logic [1:0]            status;
    logic                  accept;

    logic [63:0]           val64;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_hit  [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data;
    logic [63:0]           rd64;
    logic [31:0]           cnt32;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    pie_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .item       (s_item),
        .count      (count_reg),
        .cmd        (cmd),
        .at         (at),
        .status     (status),
        .count_next (count_next)
    );

    assign cell_cmd = accept ? cmd : '0;
    assign val64    = {32'b0, s_item.value};
    assign wr_data  = val64[DATA_WIDTH-1:0];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        pie_cell #(
            .IDX        (i),
            .IW         (IW),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .at         (at),
            .wr_data    (wr_data),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // Only the addressed cell drives nonzero hit data, so an OR selects it.
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_data = rd_data | cell_hit[i];
        end
    end

    assign rd64  = 64'(rd_data);
    assign cnt32 = 32'(count_next);

    always_comb begin
        out_next.status     = status;
        out_next.read_value = cmd.rd_en ? rd64[31:0] : 32'd0;
        out_next.count      = cnt32[4:0];
        out_next.is_empty   = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule

### tb/position_insert_erase_list_tb.sv
// Self-checking testbench for the position insert/erase list.
`timescale 1ns / 100ps

module position_insert_erase_list_tb;
    import pie_pkg::*;

    localparam int         CAP         = 16;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;
    bit         idle_en;

    // Mirrors the list contents and queues the result each accepted item should give.
    class list_scoreboard;
        logic [31:0] cells [CAP];
        int unsigned held;
        out_item_t   awaited [$];
        int unsigned errors;

        function new();
            held = 0;
            errors = 0;
        endfunction

        function void open_slot(int unsigned at, logic [31:0] v);
            for (int unsigned i = held; i > at; i--) cells[i] = cells[i - 1];
            cells[at] = v;
            held++;
        endfunction

        function void close_slot(int unsigned at);
            for (int unsigned i = at; i + 1 < held; i++) cells[i] = cells[i + 1];
            held--;
        endfunction

        function int unsigned pending_count();
            return awaited.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) $display("%t: %s", $realtime, msg);
        endfunction

        function void note_input(in_item_t it);
            out_item_t   r;
            int unsigned pos;
            r = '0;
            pos = it.position;
            case (it.mode)
                MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
                    if (held >= CAP) r.status = ST_FULL;
                    else open_slot(it.mode == MODE_PUSH_BACK ? held : 0, it.value);
                end
                MODE_POP_BACK, MODE_POP_FRONT: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else close_slot(it.mode == MODE_POP_BACK ? held - 1 : 0);
                end
                MODE_INSERT: begin
                    // A bad position wins over a full list.
                    if (pos > held) r.status = ST_BADPOS;
                    else if (held >= CAP) r.status = ST_FULL;
                    else open_slot(pos, it.value);
                end
                MODE_ERASE, MODE_READ: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else if (pos >= held) r.status = ST_BADPOS;
                    else if (it.mode == MODE_ERASE) close_slot(pos);
                    else r.read_value = cells[pos];
                end
                default: begin
                end
            endcase
            r.count = held[4:0];
            r.is_empty = (held == 0);
            awaited.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0) begin
                note_error($sformatf("result item with none awaited: status %0d rd %h count %0d",
                                     got.status, got.read_value, got.count));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.count !== want.count || got.is_empty !== want.is_empty) begin
                note_error($sformatf({"mismatch: want status %0d rd %h count %0d empty %0d, ",
                                      "got status %0d rd %h count %0d empty %0d"},
                                     want.status, want.read_value, want.count, want.is_empty,
                                     got.status, got.read_value, got.count, got.is_empty));
            end
        endfunction
    endclass

    list_scoreboard sb;

    position_insert_erase_list u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Input monitor feeds the predictor with every accepted item.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_item);
    end

    // Result side: check each accepted result, then choose the next ready.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
        m_ready <= idle_en ? ($urandom_range(99) >= 6) : 1'b1;
    end

    task automatic send_item(input in_item_t it);
        while (idle_en && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_op(input logic [2:0] mode, input logic [4:0] pos,
                           input logic [31:0] value);
        in_item_t it;
        it.mode = mode;
        it.position = pos;
        it.value = value;
        send_item(it);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_count() != 0) @(posedge aclk);
    endtask

    initial begin
        #400000;
        $display("position_insert_erase_list_tb: errors");
        $finish;
    end

    initial begin
        logic [2:0] grow_modes [3];
        logic [2:0] shrink_modes [3];
        in_item_t   it;
        bit         grow;
        int         pick;

        grow_modes   = '{MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT};
        shrink_modes = '{MODE_POP_BACK, MODE_POP_FRONT, MODE_ERASE};
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        m_ready = 1'b0;
        idle_en = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every refusal on an empty list, plus the unused mode, then a first insert at 0.
        send_op(MODE_POP_BACK, 5'd0, 32'h0);
        send_op(MODE_POP_FRONT, 5'd0, 32'h0);
        send_op(MODE_ERASE, 5'd0, 32'h0);
        send_op(MODE_READ, 5'd0, 32'h0);
        send_op(MODE_UNUSED, 5'd31, 32'hFFFF_FFFF);
        send_op(MODE_INSERT, 5'd1, 32'h1234_5678);
        send_op(MODE_INSERT, 5'd0, 32'hFFFF_FFFF);
        // Fill to capacity with every way of adding an element.
        for (int i = 1; i < CAP; i++) begin
            case (i % 4)
                0: send_op(MODE_PUSH_BACK, 5'd0, (i == 4) ? 32'h0 : $urandom);
                1: send_op(MODE_PUSH_FRONT, 5'd31, $urandom);
                2: send_op(MODE_INSERT, 5'(i / 2), $urandom);
                default: send_op(MODE_INSERT, 5'(i), $urandom);
            endcase
        end
        send_op(MODE_PUSH_BACK, 5'd0, 32'hDEAD_BEEF);
        send_op(MODE_PUSH_FRONT, 5'd0, 32'hDEAD_BEEF);
        send_op(MODE_INSERT, 5'd16, 32'hDEAD_BEEF);
        send_op(MODE_INSERT, 5'd17, 32'hDEAD_BEEF);
        send_op(MODE_READ, 5'd15, 32'h0);
        send_op(MODE_READ, 5'd16, 32'h0);
        send_op(MODE_ERASE, 5'd15, 32'h0);
        send_op(MODE_POP_FRONT, 5'd0, 32'h0);
        send_op(MODE_POP_BACK, 5'd0, 32'h0);

        // Random part: alternate growing and shrinking phases so the list
        // swings between empty and full.
        for (int n = 0; n < 1300; n++) begin
            grow = ((n / 100) % 2) == 0;
            idle_en = !(n >= 300 && n < 600);
            if (n == 800) wait_drained();
            pick = $urandom_range(99);
            if (pick < 3) it.mode = MODE_UNUSED;
            else if (pick < 18) it.mode = MODE_READ;
            else if (pick < 72) it.mode = grow ? grow_modes[$urandom_range(2)]
                                               : shrink_modes[$urandom_range(2)];
            else it.mode = grow ? shrink_modes[$urandom_range(2)]
                                : grow_modes[$urandom_range(2)];
            it.position = ($urandom_range(99) < 85) ? 5'($urandom_range(16))
                                                    : 5'($urandom_range(31));
            pick = $urandom_range(99);
            if (pick < 10) it.value = 32'h0;
            else if (pick < 20) it.value = 32'hFFFF_FFFF;
            else it.value = $urandom;
            send_item(it);
        end
        idle_en = 1'b1;

        wait_drained();
        repeat (5) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("position_insert_erase_list_tb: clean");
        end else begin
            $display("position_insert_erase_list_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
sv/pie_pkg.sv
sv/pie_cell.sv
sv/pie_ctrl.sv
sv/position_insert_erase_list.sv
tb/position_insert_erase_list_tb.sv
